FILE: rtl/core/pbdt_pkg.sv
// Package for the permutation BFS distance table: request and result types,
// generator tables, Lehmer factorial weights and permutation helpers.
// No dependencies.
package pbdt_pkg;

	localparam int NUM_ITEMS = 7;
	localparam int NUM_PERMS = 5040;
	localparam int NUM_GENS  = 7;
	localparam int IDX_W     = 13;
	localparam int DIST_W    = 8;

	localparam logic [1:0] MODE_BUILD  = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_PRED   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_BUILT = 2'd1;
	localparam logic [1:0] ST_NO_PRED   = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	localparam logic OP_UNRANK = 1'b0;
	localparam logic OP_RANK   = 1'b1;

	typedef logic [NUM_ITEMS-1:0][2:0] perm_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] row_index;
	} request_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  other_index;
		logic [2:0]        call_code;
		logic [2:0]        bell_0;
		logic [2:0]        bell_1;
		logic [2:0]        bell_2;
		logic [2:0]        bell_3;
		logic [2:0]        bell_4;
		logic [2:0]        bell_5;
		logic [2:0]        bell_6;
	} result_t;

	typedef struct packed {
		logic start;
		logic op;
	} codec_req_t;

	// weight of each Lehmer digit, (NUM_ITEMS-1-i)!
	localparam logic [IDX_W-1:0] FACT_TAB [8] = '{
		13'd720, 13'd120, 13'd24, 13'd6, 13'd2, 13'd1, 13'd1, 13'd1};

	// forward generators pp, pb, bp, ps, sp, bs, bb: b[i] = a[g[i]]
	localparam logic [2:0] GEN_TAB [8][NUM_ITEMS] = '{
		'{3'd1, 3'd3, 3'd5, 3'd6, 3'd0, 3'd4, 3'd2},
		'{3'd1, 3'd3, 3'd5, 3'd2, 3'd0, 3'd6, 3'd4},
		'{3'd1, 3'd3, 3'd4, 3'd5, 3'd0, 3'd6, 3'd2},
		'{3'd1, 3'd3, 3'd5, 3'd2, 3'd0, 3'd4, 3'd6},
		'{3'd1, 3'd3, 3'd4, 3'd6, 3'd0, 3'd5, 3'd2},
		'{3'd1, 3'd3, 3'd4, 3'd2, 3'd0, 3'd6, 3'd5},
		'{3'd1, 3'd3, 3'd4, 3'd2, 3'd0, 3'd5, 3'd6},
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6}};

	// trace-back order pp, pb, ps, bp, sp, bb, bs
	localparam logic [2:0] BACK_TAB [8] = '{
		3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd6, 3'd5, 3'd7};

	function automatic perm_t apply_fwd(perm_t a, logic [2:0] k);
		perm_t b;
		for (int i = 0; i < NUM_ITEMS; i++) begin
			b[i] = a[GEN_TAB[k][i]];
		end
		return b;
	endfunction

	function automatic perm_t apply_inv(perm_t a, logic [2:0] k);
		perm_t b;
		b = a;
		for (int i = 0; i < NUM_ITEMS; i++) begin
			b[GEN_TAB[k][i]] = a[i];
		end
		return b;
	endfunction

endpackage

FILE: rtl/core/pbdt_codec.sv
// Iterative Lehmer rank / unrank unit, one digit per cycle.
// Depends on pbdt_pkg.
module pbdt_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbdt_pkg::codec_req_t          req,
	input  logic [pbdt_pkg::IDX_W-1:0]    idx_in,
	input  pbdt_pkg::perm_t               perm_in,
	output logic                          done,
	output logic [pbdt_pkg::IDX_W-1:0]    idx_out,
	output pbdt_pkg::perm_t               perm_out
);

	logic                       run_q;
	logic                       op_q;
	logic [2:0]                 step_q;
	logic                       done_q;
	logic [pbdt_pkg::IDX_W-1:0] idx_q;
	pbdt_pkg::perm_t            perm_q;
	pbdt_pkg::perm_t            pool_q;

	logic [pbdt_pkg::IDX_W-1:0] f;
	logic [2:0]                 d;
	logic [2:0]                 cnt;
	logic [2:0]                 c;
	pbdt_pkg::perm_t            pool_nx;

	always_comb begin
		f   = pbdt_pkg::FACT_TAB[step_q];
		cnt = 3'(pbdt_pkg::NUM_ITEMS) - step_q;
		d   = '0;
		for (int m = 1; m < pbdt_pkg::NUM_ITEMS; m++) begin
			if (idx_q >= 13'(m) * f)
				d = 3'(m);
		end
		if (d >= cnt)
			d = cnt - 3'd1;
		pool_nx = pool_q;
		for (int j = 0; j < pbdt_pkg::NUM_ITEMS - 1; j++) begin
			if (3'(j) >= d)
				pool_nx[j] = pool_q[j+1];
		end
		// later items smaller than the current one
		c = '0;
		for (int j = 1; j < pbdt_pkg::NUM_ITEMS; j++) begin
			if (3'(j) > step_q && perm_q[j] < perm_q[step_q])
				c = c + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			op_q   <= pbdt_pkg::OP_UNRANK;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				op_q   <= req.op;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if ((op_q == pbdt_pkg::OP_UNRANK && step_q == 3'd6) ||
				    (op_q == pbdt_pkg::OP_RANK && step_q == 3'd5)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == pbdt_pkg::OP_UNRANK) begin
				idx_q <= idx_in;
				for (int i = 0; i < pbdt_pkg::NUM_ITEMS; i++) begin
					pool_q[i] <= 3'(i + 1);
				end
			end else begin
				idx_q  <= '0;
				perm_q <= perm_in;
			end
		end else if (run_q) begin
			if (op_q == pbdt_pkg::OP_UNRANK) begin
				perm_q[step_q] <= pool_q[d];
				pool_q         <= pool_nx;
				idx_q          <= idx_q - 13'(d) * f;
			end else begin
				idx_q <= idx_q + 13'(c) * f;
			end
		end
	end

	assign done     = done_q;
	assign idx_out  = idx_q;
	assign perm_out = perm_q;

endmodule

FILE: rtl/core/permutation_bfs_distance_table.sv
// Permutation BFS distance table, top level: sequencer, distance store and
// search queue. Depends on pbdt_pkg and pbdt_codec.
//
// Use: a request (mode, row_index) is taken on a clock edge with start high
// and busy low. Exactly one result follows on result, marked by a one-cycle
// done strobe; the receiver must take it then, there is no back-pressure.
// For a request that starts work, busy rises at the accepting edge and falls
// as its result is shown; unused-mode and out-of-range requests never raise it.
// Build (mode 0): a clearing sweep of the 5040-entry store, then a
// breadth-first walk from the identity. Per table row: pop, read depth,
// unrank, then rank each of the seven moves on the shared rank/unrank unit
// and mark unseen ones. Result: greatest depth and the identity permutation.
// Lookup (mode 1): one store read and seven unrank digits.
// Predecessor (mode 2): lookup plus up to seven trials, each an inverse move,
// six rank digits and one store read.
// Unused mode and out-of-range ranks answer on the accepting edge itself.
// Reset clears the sequencer and marks the table not built; the store itself
// is not cleared at reset and reads as zero until the first build.
// The next request may be taken in the cycle that done is shown.
module permutation_bfs_distance_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pbdt_pkg::request_t req,
	output logic               done,
	output pbdt_pkg::result_t  result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_INIT = 4'd2;
	localparam logic [3:0] S_POP  = 4'd3;
	localparam logic [3:0] S_RDQ  = 4'd4;
	localparam logic [3:0] S_RDD  = 4'd5;
	localparam logic [3:0] S_UNR  = 4'd6;
	localparam logic [3:0] S_GEN  = 4'd7;
	localparam logic [3:0] S_RNK  = 4'd8;
	localparam logic [3:0] S_CHK  = 4'd9;
	localparam logic [3:0] S_LRD  = 4'd10;
	localparam logic [3:0] S_LUNR = 4'd11;
	localparam logic [3:0] S_PGEN = 4'd12;
	localparam logic [3:0] S_PRNK = 4'd13;
	localparam logic [3:0] S_PCHK = 4'd14;

	localparam logic [pbdt_pkg::IDX_W-1:0] PERMS = 13'(pbdt_pkg::NUM_PERMS);
	localparam logic [pbdt_pkg::IDX_W-1:0] LAST  = 13'(pbdt_pkg::NUM_PERMS - 1);

	logic [3:0]                  state_q;
	logic                        ready_q;
	logic                        done_q;
	pbdt_pkg::result_t           res_q;
	logic [1:0]                  mode_q;
	logic [pbdt_pkg::IDX_W-1:0]  cur_q;
	logic [pbdt_pkg::IDX_W-1:0]  head_q;
	logic [pbdt_pkg::IDX_W-1:0]  tail_q;
	logic [pbdt_pkg::IDX_W-1:0]  clr_q;
	logic [pbdt_pkg::IDX_W-1:0]  p_q;
	logic [pbdt_pkg::DIST_W-1:0] depth_q;
	logic [pbdt_pkg::DIST_W-1:0] nd_q;
	logic [pbdt_pkg::DIST_W-1:0] dist_q;
	logic [2:0]                  k_q;
	pbdt_pkg::perm_t             a_q;
	pbdt_pkg::perm_t             b_q;

	// store word: {visited, distance}
	logic [pbdt_pkg::DIST_W:0]   store_mem [pbdt_pkg::NUM_PERMS];
	logic [pbdt_pkg::IDX_W-1:0]  queue_mem [pbdt_pkg::NUM_PERMS];
	logic [pbdt_pkg::DIST_W:0]   st_rd_q;
	logic [pbdt_pkg::IDX_W-1:0]  q_rd_q;
	logic                        st_we;
	logic [pbdt_pkg::IDX_W-1:0]  st_wa;
	logic [pbdt_pkg::DIST_W:0]   st_wd;
	logic [pbdt_pkg::IDX_W-1:0]  st_ra;
	logic                        q_we;
	logic [pbdt_pkg::IDX_W-1:0]  q_wa;
	logic [pbdt_pkg::IDX_W-1:0]  q_wd;

	pbdt_pkg::codec_req_t        cq;
	logic [pbdt_pkg::IDX_W-1:0]  cidx_in;
	pbdt_pkg::perm_t             cperm_in;
	logic                        cdone;
	logic [pbdt_pkg::IDX_W-1:0]  cidx;
	pbdt_pkg::perm_t             cperm;

	logic [pbdt_pkg::DIST_W-1:0] dmax;
	logic [pbdt_pkg::DIST_W-1:0] dlook;
	pbdt_pkg::perm_t             ident;
	pbdt_pkg::perm_t             fwd;
	pbdt_pkg::perm_t             inv;

	pbdt_codec u_codec (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (cq),
		.idx_in   (cidx_in),
		.perm_in  (cperm_in),
		.done     (cdone),
		.idx_out  (cidx),
		.perm_out (cperm)
	);

	always_comb begin
		for (int i = 0; i < pbdt_pkg::NUM_ITEMS; i++) begin
			ident[i] = 3'(i + 1);
		end
		fwd   = pbdt_pkg::apply_fwd(a_q, k_q);
		inv   = pbdt_pkg::apply_inv(a_q, pbdt_pkg::BACK_TAB[k_q]);
		dmax  = (st_rd_q[pbdt_pkg::DIST_W-1:0] > depth_q) ?
			st_rd_q[pbdt_pkg::DIST_W-1:0] : depth_q;
		// before any build the store is taken as all zero
		dlook = ready_q ? st_rd_q[pbdt_pkg::DIST_W-1:0] : '0;

		cq.start = 1'b0;
		cq.op    = pbdt_pkg::OP_UNRANK;
		cidx_in  = cur_q;
		cperm_in = fwd;
		unique case (state_q)
			S_RDD, S_LRD: cq.start = 1'b1;
			S_GEN: begin
				cq.start = 1'b1;
				cq.op    = pbdt_pkg::OP_RANK;
			end
			S_PGEN: begin
				cq.start = 1'b1;
				cq.op    = pbdt_pkg::OP_RANK;
				cperm_in = inv;
			end
			default: ;
		endcase

		st_we = 1'b0;
		st_wa = clr_q;
		st_wd = '0;
		q_we  = 1'b0;
		q_wa  = tail_q;
		q_wd  = '0;
		st_ra = cur_q;
		unique case (state_q)
			S_CLR: st_we = 1'b1;
			S_INIT: begin
				st_we = 1'b1;
				st_wa = '0;
				st_wd = {1'b1, {pbdt_pkg::DIST_W{1'b0}}};
				q_we  = 1'b1;
				q_wa  = '0;
			end
			S_RDQ: st_ra = q_rd_q;
			S_RNK, S_PRNK: st_ra = cidx;
			S_CHK: begin
				st_we = !st_rd_q[pbdt_pkg::DIST_W] && (tail_q < PERMS);
				st_wa = p_q;
				st_wd = {1'b1, nd_q};
				q_we  = st_we;
				q_wd  = p_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_wa] <= st_wd;
		st_rd_q <= store_mem[st_ra];
		if (q_we)
			queue_mem[q_wa] <= q_wd;
		q_rd_q <= queue_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
			mode_q  <= pbdt_pkg::MODE_BUILD;
			cur_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			depth_q <= '0;
			nd_q    <= '0;
			dist_q  <= '0;
			clr_q   <= '0;
			p_q     <= '0;
			k_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= req.mode;
						cur_q  <= req.row_index;
						res_q  <= '0;
						if (req.mode == pbdt_pkg::MODE_BUILD) begin
							clr_q   <= '0;
							state_q <= S_CLR;
						end else if (req.mode != pbdt_pkg::MODE_LOOKUP &&
						             req.mode != pbdt_pkg::MODE_PRED) begin
							done_q <= 1'b1;
						end else if (req.row_index >= PERMS) begin
							res_q.status <= pbdt_pkg::ST_RANGE;
							done_q       <= 1'b1;
						end else begin
							state_q <= S_LRD;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 13'd1;
					if (clr_q == LAST)
						state_q <= S_INIT;
				end
				S_INIT: begin
					head_q  <= '0;
					tail_q  <= 13'd1;
					depth_q <= '0;
					state_q <= S_POP;
				end
				S_POP: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + 13'd1;
						state_q <= S_RDQ;
					end else begin
						ready_q         <= 1'b1;
						res_q.distance  <= depth_q;
						{res_q.bell_0, res_q.bell_1, res_q.bell_2, res_q.bell_3,
						 res_q.bell_4, res_q.bell_5, res_q.bell_6} <=
							{ident[0], ident[1], ident[2], ident[3],
							 ident[4], ident[5], ident[6]};
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_RDQ: begin
					cur_q   <= q_rd_q;
					state_q <= S_RDD;
				end
				S_RDD: begin
					depth_q <= dmax;
					nd_q    <= (dmax == 8'hFF) ? dmax : dmax + 8'd1;
					state_q <= S_UNR;
				end
				S_UNR: begin
					if (cdone) begin
						a_q     <= cperm;
						k_q     <= '0;
						state_q <= S_GEN;
					end
				end
				S_GEN: state_q <= S_RNK;
				S_RNK: begin
					if (cdone) begin
						p_q     <= cidx;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (st_we)
						tail_q <= tail_q + 13'd1;
					k_q <= k_q + 3'd1;
					state_q <= (k_q == 3'(pbdt_pkg::NUM_GENS - 1)) ? S_POP : S_GEN;
				end
				S_LRD: state_q <= S_LUNR;
				S_LUNR: begin
					if (cdone) begin
						a_q    <= cperm;
						dist_q <= dlook;
						k_q    <= '0;
						res_q.distance <= dlook;
						{res_q.bell_0, res_q.bell_1, res_q.bell_2, res_q.bell_3,
						 res_q.bell_4, res_q.bell_5, res_q.bell_6} <=
							{cperm[0], cperm[1], cperm[2], cperm[3],
							 cperm[4], cperm[5], cperm[6]};
						priority if (!ready_q) begin
							res_q.status <= pbdt_pkg::ST_NOT_BUILT;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else if (mode_q == pbdt_pkg::MODE_LOOKUP) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (dlook == '0) begin
							res_q.status <= pbdt_pkg::ST_NO_PRED;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_PGEN;
						end
					end
				end
				S_PGEN: begin
					b_q     <= inv;
					state_q <= S_PRNK;
				end
				S_PRNK: begin
					if (cdone) begin
						p_q     <= cidx;
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (st_rd_q[pbdt_pkg::DIST_W-1:0] == dist_q - 8'd1) begin
						res_q.distance    <= st_rd_q[pbdt_pkg::DIST_W-1:0];
						res_q.other_index <= p_q;
						res_q.call_code   <= k_q;
						{res_q.bell_0, res_q.bell_1, res_q.bell_2, res_q.bell_3,
						 res_q.bell_4, res_q.bell_5, res_q.bell_6} <=
							{b_q[0], b_q[1], b_q[2], b_q[3], b_q[4], b_q[5], b_q[6]};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (k_q == 3'(pbdt_pkg::NUM_GENS - 1)) begin
						res_q.status <= pbdt_pkg::ST_NO_PRED;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_PGEN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// a result is only ever shown with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// every accepted request either starts work or answers at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("request dropped");

	// queue pointers stay ordered and inside the store
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= tail_q || state_q == S_CLR || state_q == S_INIT) &&
		tail_q <= PERMS) else $error("search queue pointers out of order");

endmodule

FILE: dv/pbdt_checker.sv
// Checker for the permutation BFS distance table: watches request and result
// channels, keeps its own distance table and compares every result.
// Depends on pbdt_pkg.
`timescale 1ns / 100ps

module pbdt_checker (
	input  logic               clk,
	input  logic               start,
	input  logic               busy,
	input  pbdt_pkg::request_t req,
	input  logic               done,
	input  pbdt_pkg::result_t  result,
	output int                 fail_count,
	output int                 pending
);

	typedef logic [2:0] bell_arr_t [7];

	// forward moves pp, pb, bp, ps, sp, bs, bb: b[i] = a[move[i]]
	localparam int MOVES [7][7] = '{
		'{1, 3, 5, 6, 0, 4, 2},
		'{1, 3, 5, 2, 0, 6, 4},
		'{1, 3, 4, 5, 0, 6, 2},
		'{1, 3, 5, 2, 0, 4, 6},
		'{1, 3, 4, 6, 0, 5, 2},
		'{1, 3, 4, 2, 0, 6, 5},
		'{1, 3, 4, 2, 0, 5, 6}};
	// trace-back order pp, pb, ps, bp, sp, bb, bs
	localparam int TRACE [7] = '{0, 1, 3, 2, 4, 6, 5};
	localparam int WEIGHT [7] = '{720, 120, 24, 6, 2, 1, 1};

	logic [7:0]        depth_of [pbdt_pkg::NUM_PERMS];
	bit                built;
	// at most two requests are ever in flight
	pbdt_pkg::result_t awaited [4];
	int                wr_n, rd_n;

	function automatic int lehmer_rank(bell_arr_t a);
		int r, c;
		r = 0;
		for (int i = 0; i < 6; i++) begin
			c = 0;
			for (int j = i + 1; j < 7; j++)
				if (a[j] < a[i]) c++;
			r += c * WEIGHT[i];
		end
		return r;
	endfunction

	function automatic bell_arr_t lehmer_unrank(int idx);
		bell_arr_t a;
		logic [2:0] pool [7];
		int cnt, d;
		cnt = 7;
		for (int i = 0; i < 7; i++) pool[i] = 3'(i + 1);
		for (int i = 0; i < 7; i++) begin
			d = idx / WEIGHT[i];
			idx = idx % WEIGHT[i];
			if (d >= cnt) d = cnt - 1;
			a[i] = pool[d];
			for (int j = d; j + 1 < cnt; j++) pool[j] = pool[j + 1];
			cnt--;
		end
		return a;
	endfunction

	function automatic pbdt_pkg::result_t with_bells(pbdt_pkg::result_t r, bell_arr_t a);
		pbdt_pkg::result_t o;
		o = r;
		o.bell_0 = a[0]; o.bell_1 = a[1]; o.bell_2 = a[2]; o.bell_3 = a[3];
		o.bell_4 = a[4]; o.bell_5 = a[5]; o.bell_6 = a[6];
		return o;
	endfunction

	// breadth-first walk from the identity; returns greatest depth
	function automatic logic [7:0] walk_table();
		int         order [pbdt_pkg::NUM_PERMS];
		int         head_n, tail_n;
		bit         seen [pbdt_pkg::NUM_PERMS];
		logic [7:0] deepest, nd;
		int         cur, nr;
		bell_arr_t  a, b;
		deepest = 0;
		foreach (depth_of[i]) begin
			depth_of[i] = 0;
			seen[i] = 0;
		end
		head_n = 0;
		tail_n = 1;
		order[0] = 0;
		seen[0] = 1;
		while (head_n < tail_n) begin
			cur = order[head_n];
			head_n++;
			if (depth_of[cur] > deepest) deepest = depth_of[cur];
			nd = (deepest == 8'd255) ? 8'd255 : deepest + 8'd1;
			a = lehmer_unrank(cur);
			for (int k = 0; k < 7; k++) begin
				for (int i = 0; i < 7; i++) b[i] = a[MOVES[k][i]];
				nr = lehmer_rank(b);
				if (!seen[nr] && tail_n < pbdt_pkg::NUM_PERMS) begin
					seen[nr] = 1;
					depth_of[nr] = nd;
					order[tail_n] = nr;
					tail_n++;
				end
			end
		end
		built = 1;
		return deepest;
	endfunction

	function automatic pbdt_pkg::result_t predict_answer(pbdt_pkg::request_t rq);
		pbdt_pkg::result_t r;
		bell_arr_t         a, b;
		int                p, idx;
		r = '0;
		idx = int'(rq.row_index);
		if (rq.mode == pbdt_pkg::MODE_BUILD) begin
			r.distance = walk_table();
			r = with_bells(r, lehmer_unrank(0));
			return r;
		end
		if (rq.mode != pbdt_pkg::MODE_LOOKUP && rq.mode != pbdt_pkg::MODE_PRED) return r;
		if (idx >= pbdt_pkg::NUM_PERMS) begin
			r.status = pbdt_pkg::ST_RANGE;
			return r;
		end
		a = lehmer_unrank(idx);
		r.distance = depth_of[idx];
		r = with_bells(r, a);
		if (!built) begin
			r.status = pbdt_pkg::ST_NOT_BUILT;
			return r;
		end
		if (rq.mode == pbdt_pkg::MODE_LOOKUP) return r;
		if (depth_of[idx] != 0) begin
			for (int k = 0; k < 7; k++) begin
				for (int i = 0; i < 7; i++) b[MOVES[TRACE[k]][i]] = a[i];
				p = lehmer_rank(b);
				if (depth_of[p] == depth_of[idx] - 8'd1) begin
					r.distance = depth_of[p];
					r.other_index = p[pbdt_pkg::IDX_W-1:0];
					r.call_code = 3'(k);
					r = with_bells(r, b);
					return r;
				end
			end
		end
		r.status = pbdt_pkg::ST_NO_PRED;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		wr_n = 0;
		rd_n = 0;
		built = 0;
		foreach (depth_of[i]) depth_of[i] = 0;
	end

	assign pending = wr_n - rd_n;

	always @(posedge clk) begin
		pbdt_pkg::result_t e;
		if (start && !busy) begin
			awaited[wr_n % 4] = predict_answer(req);
			wr_n++;
		end
		if (done) begin
			if (wr_n == rd_n) begin
				$display("%0t: unexpected result %h", $realtime, result);
				fail_count++;
			end else begin
				e = awaited[rd_n % 4];
				rd_n++;
				check_field("status", e.status, result.status);
				check_field("distance", e.distance, result.distance);
				check_field("other_index", e.other_index, result.other_index);
				check_field("call_code", e.call_code, result.call_code);
				check_field("bell_0", e.bell_0, result.bell_0);
				check_field("bell_1", e.bell_1, result.bell_1);
				check_field("bell_2", e.bell_2, result.bell_2);
				check_field("bell_3", e.bell_3, result.bell_3);
				check_field("bell_4", e.bell_4, result.bell_4);
				check_field("bell_5", e.bell_5, result.bell_5);
				check_field("bell_6", e.bell_6, result.bell_6);
			end
		end
	end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the permutation BFS distance table: clock, reset, request
// stimulus, watchdog and verdict. Depends on pbdt_pkg, pbdt_checker and the table.
`timescale 1ns / 100ps

module tb_top;

	// a build walks the whole table with nothing accepted
	localparam int QUIET_LIMIT = 1500000;
	localparam int RANDOM_REQUESTS = 1800;

	logic               clk, arst_n, start, busy, done;
	pbdt_pkg::request_t req;
	pbdt_pkg::result_t  result;
	int                 fail_count, pending, quiet_cycles;

	permutation_bfs_distance_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .result(result));

	pbdt_checker chk (
		.clk(clk), .start(start), .busy(busy), .req(req), .done(done),
		.result(result), .fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog: cycles since the last request or result was taken
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// present one request and hold it until taken; start stays high for the next
	task automatic send_request(logic [1:0] mode, logic [pbdt_pkg::IDX_W-1:0] idx);
		req   <= '{mode: mode, row_index: idx};
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic maybe_idle(bit allowed);
		if (allowed && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin
		int m;
		logic [pbdt_pkg::IDX_W-1:0] idx;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any build: not-built answers, range check first, unused mode
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd0);
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd5039);
		send_request(pbdt_pkg::MODE_PRED, 13'd5039);
		send_request(pbdt_pkg::MODE_PRED, 13'd0);
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd5040);
		send_request(pbdt_pkg::MODE_PRED, 13'h1FFF);
		send_request(pbdt_pkg::MODE_UNUSED, 13'h1FFF);
		// the single build; row_index is ignored
		send_request(pbdt_pkg::MODE_BUILD, 13'h1FFF);
		// identity has no predecessor, the far corners, out of range and an unused mode
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd0);
		send_request(pbdt_pkg::MODE_PRED, 13'd0);
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd5039);
		send_request(pbdt_pkg::MODE_PRED, 13'd5039);
		send_request(pbdt_pkg::MODE_PRED, 13'd1);
		send_request(pbdt_pkg::MODE_PRED, 13'd2520);
		send_request(pbdt_pkg::MODE_LOOKUP, 13'd4095);
		send_request(pbdt_pkg::MODE_LOOKUP, 13'h1FFF);
		send_request(pbdt_pkg::MODE_PRED, 13'd5040);
		send_request(pbdt_pkg::MODE_UNUSED, 13'd0);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			maybe_idle(n < 600 || n > 1000);
			m = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 8)
				idx = 13'($urandom_range(pbdt_pkg::NUM_PERMS, 8191));
			else idx = 13'($urandom_range(0, pbdt_pkg::NUM_PERMS - 1));
			if (m < 40) send_request(pbdt_pkg::MODE_LOOKUP, idx);
			else if (m < 95) send_request(pbdt_pkg::MODE_PRED, idx);
			else send_request(pbdt_pkg::MODE_UNUSED, 13'($urandom()));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
